// File: sv/first_fit_slot_allocator_top_macros.svh
// Assertion macros for the first-fit slot allocator checker.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef FIRST_FIT_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FFSA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffsa checker: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define FFSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffsa checker: next-cycle property failed");

`endif

// File: sv/ffsa_pkg.sv
// Shared types and constants of the first-fit slot allocator.
// No dependencies; used by every module of the block.
`default_nettype none

package ffsa_pkg;

   // Fixed field widths of the request and result transfers.
   localparam int SLOT_W = 5;
   localparam int OUT_W  = 6;

   // Request function codes.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic              func;
      logic [SLOT_W-1:0] start_slot;
      logic [SLOT_W-1:0] end_slot;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] chosen_resource;
      logic [OUT_W-1:0] resources_in_use;
      logic             overflow;
   } rsp_type;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic active;
      logic placed;
   } tok_type;

endpackage

`default_nettype wire

// File: sv/ffsa_cell.sv
// One resource cell: holds one occupancy bitmap and passes the search token on.
// Depends on ffsa_pkg for the token type.
`default_nettype none

module ffsa_cell #(
   parameter int NUM_SLOTS = 24,
   parameter int RES_W     = 6,
   parameter int CELL_NUM  = 1
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     clear,
   input  wire [NUM_SLOTS-1:0]     mask,
   input  ffsa_pkg::tok_type       up_tok,
   input  wire [RES_W-1:0]         up_chosen,
   output ffsa_pkg::tok_type       dn_tok,
   output logic [RES_W-1:0]        dn_chosen
);
   import ffsa_pkg::*;

   logic [NUM_SLOTS-1:0] occ_ff, occ_in;
   tok_type              tok_ff, tok_in;
   logic [RES_W-1:0]     chosen_ff, chosen_in;
   logic                 take;

   // The first free cell the token meets claims the range.
   assign take = up_tok.active && !up_tok.placed && ((occ_ff & mask) == '0);

   always_comb begin
      tok_in.active = up_tok.active;
      tok_in.placed = up_tok.placed | take;
      chosen_in     = take ? RES_W'(CELL_NUM) : up_chosen;
      if (clear) begin
         occ_in = '0;
      end else if (take) begin
         occ_in = occ_ff | mask;
      end else begin
         occ_in = occ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
         occ_ff <= '0;
      end else begin
         tok_ff <= tok_in;
         occ_ff <= occ_in;
      end
      chosen_ff <= chosen_in;
   end

   assign dn_tok    = tok_ff;
   assign dn_chosen = chosen_ff;

endmodule

`default_nettype wire

// File: sv/first_fit_slot_allocator_top.sv
// Top level of the first-fit slot allocator: request control and the cell chain.
// Depends on ffsa_pkg and ffsa_cell.
//
// Usage:
//  - A request transfer takes place at a rising edge where start is high and
//    busy is low. req_item carries func, start_slot and end_slot.
//  - An allocate request sends a token down a chain of NUM_RESOURCES cells, one
//    cell per cycle; the first cell whose bitmap is free on the range claims it.
//    The result strobe rsp_valid rises once the token has left the last cell
//    and the result is registered, and busy stays high until the result is
//    registered, so no new request is taken while an allocate is in the chain.
//  - A clear request empties every bitmap at once and its result appears in
//    the next cycle; busy does not rise and a new request may follow at once.
//  - Each result is shown for exactly one cycle with rsp_valid high; the
//    receiver cannot stall it.
//  - Reset clears all bitmaps, sets the resource count to one and drops busy.
`default_nettype none

module first_fit_slot_allocator_top #(
   parameter int NUM_RESOURCES = 32,
   parameter int NUM_SLOTS     = 24
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  ffsa_pkg::req_type  req_item,
   output logic               rsp_valid,
   output ffsa_pkg::rsp_type  rsp_item
);
   import ffsa_pkg::*;

   localparam int RES_W = $clog2(NUM_RESOURCES + 1);
   localparam int CMP_W = 7;

   logic                 busy_ff, busy_in;
   logic                 inject_ff, inject_in;
   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic [RES_W-1:0]     count_ff, count_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 accept;
   logic                 clear_now;
   logic [NUM_SLOTS-1:0] range_mask;

   tok_type              tok_chain [NUM_RESOURCES+1];
   logic [RES_W-1:0]     chosen_chain [NUM_RESOURCES+1];
   tok_type              last_tok;
   logic [RES_W-1:0]     last_chosen;

   assign accept = start && !busy_ff;

   // Slot mask of the half-open range; slots past the end of the map drop out.
   always_comb begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
         range_mask[j] = (CMP_W'(j) >= CMP_W'(req_item.start_slot)) &&
                         (CMP_W'(j) <  CMP_W'(req_item.end_slot));
      end
   end

   // The token enters the first cell in the cycle after the transfer.
   assign tok_chain[0].active = inject_ff;
   assign tok_chain[0].placed = 1'b0;
   assign chosen_chain[0]     = '0;

   for (genvar i = 0; i < NUM_RESOURCES; i++) begin : g_cell
      ffsa_cell #(
         .NUM_SLOTS (NUM_SLOTS),
         .RES_W     (RES_W),
         .CELL_NUM  (i + 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (clear_now),
         .mask      (mask_ff),
         .up_tok    (tok_chain[i]),
         .up_chosen (chosen_chain[i]),
         .dn_tok    (tok_chain[i+1]),
         .dn_chosen (chosen_chain[i+1])
      );
   end

   assign last_tok    = tok_chain[NUM_RESOURCES];
   assign last_chosen = chosen_chain[NUM_RESOURCES];

   // Request control and result formation.
   always_comb begin
      busy_in    = busy_ff;
      inject_in  = 1'b0;
      mask_in    = mask_ff;
      count_in   = count_ff;
      rsp_vld_in = 1'b0;
      rsp_in     = rsp_ff;
      clear_now  = 1'b0;

      if (accept) begin
         if (req_item.func == FUNC_CLEAR) begin
            clear_now               = 1'b1;
            count_in                = RES_W'(1);
            rsp_vld_in              = 1'b1;
            rsp_in.chosen_resource  = '0;
            rsp_in.resources_in_use = OUT_W'(1);
            rsp_in.overflow         = 1'b0;
         end else begin
            busy_in   = 1'b1;
            inject_in = 1'b1;
            mask_in   = range_mask;
         end
      end

      // The token leaving the last cell finishes the allocate.
      if (last_tok.active) begin
         busy_in    = 1'b0;
         rsp_vld_in = 1'b1;
         if (last_tok.placed) begin
            if (last_chosen > count_ff) begin
               count_in = last_chosen;
            end
            rsp_in.chosen_resource  = OUT_W'(last_chosen);
            rsp_in.resources_in_use = OUT_W'(count_in);
            rsp_in.overflow         = 1'b0;
         end else begin
            rsp_in.chosen_resource  = '0;
            rsp_in.resources_in_use = OUT_W'(count_ff);
            rsp_in.overflow         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         inject_ff  <= 1'b0;
         count_ff   <= RES_W'(1);
         rsp_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         inject_ff  <= inject_in;
         count_ff   <= count_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      mask_ff <= mask_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// File: sv/ffsa_checker.sv
// Port-level checker for the first-fit slot allocator, bound to the top level.
// Depends on ffsa_pkg and first_fit_slot_allocator_top_macros.svh.
`default_nettype none

`include "first_fit_slot_allocator_top_macros.svh"

module ffsa_checker (
   input wire                clock,
   input wire                reset,
   input wire                start,
   input wire                busy,
   input ffsa_pkg::req_type  req_item,
   input wire                rsp_valid,
   input ffsa_pkg::rsp_type  rsp_item
);
   import ffsa_pkg::*;

   // A clear transfer yields a reset-count result in the next cycle.
   `FFSA_ASSERT_NEXT(a_clear_result, start && !busy && req_item.func == FUNC_CLEAR, rsp_valid && rsp_item.chosen_resource == '0 && rsp_item.resources_in_use == OUT_W'(1) && !rsp_item.overflow)

   // An allocate transfer holds the block busy with no result in the next cycle.
   `FFSA_ASSERT_NEXT(a_alloc_busy, start && !busy && req_item.func == FUNC_ALLOC, busy && !rsp_valid)

   // A result is never shown while a search is still in the chain.
   `FFSA_ASSERT_NOW(a_no_rsp_busy, rsp_valid, !busy)

   // An overflow result names no resource.
   `FFSA_ASSERT_NOW(a_ovf_unplaced, rsp_valid && rsp_item.overflow, rsp_item.chosen_resource == '0)

endmodule

bind first_fit_slot_allocator_top ffsa_checker u_ffsa_checker (.*);

`default_nettype wire
